/* src/assert_macros.svh */
// Assertion macros shared by the trace window statistics design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

/* src/tws_pkg.sv */
// Types and constants of the trace window statistics block.
`timescale 1ns / 1ps
package tws_pkg;
   localparam logic [4:0] MAX_DIVISIONS = 5'd16;
   localparam logic [14:0] POINT_CAP = 15'd32767;
   localparam int QUEUE_DEPTH = 4;

   localparam logic REG_DIVISION_COUNT = 1'b0;
   localparam logic REG_THICKNESS_LIMIT = 1'b1;

   localparam logic [2:0] DIV_SEL_MEAN = 3'd0;
   localparam logic [2:0] DIV_SEL_MEANSQ = 3'd1;
   localparam logic [2:0] DIV_SEL_MEANABS = 3'd2;
   localparam logic [2:0] DIV_SEL_MEANPOS = 3'd3;
   localparam logic [2:0] DIV_SEL_MEANNEG = 3'd4;

   localparam logic [3:0] STAT_MIN = 4'd0;
   localparam logic [3:0] STAT_MAX = 4'd1;
   localparam logic [3:0] STAT_MEAN = 4'd2;
   localparam logic [3:0] STAT_VAR = 4'd3;
   localparam logic [3:0] STAT_RMS = 4'd4;
   localparam logic [3:0] STAT_MAXABS = 4'd5;
   localparam logic [3:0] STAT_MEANABS = 4'd6;
   localparam logic [3:0] STAT_SUMABS = 4'd7;
   localparam logic [3:0] STAT_MAXPOS = 4'd8;
   localparam logic [3:0] STAT_MEANPOS = 4'd9;
   localparam logic [3:0] STAT_SUMPOS = 4'd10;
   localparam logic [3:0] STAT_MAXNEG = 4'd11;
   localparam logic [3:0] STAT_MEANNEG = 4'd12;
   localparam logic [3:0] STAT_SUMNEG = 4'd13;

   typedef enum logic [1:0] {F_IDLE, F_DIV, F_INTERP, F_SAMPLE} front_state_type;

   typedef enum logic [2:0] {
      B_POP, B_ADD, B_DSTART, B_DWAIT, B_MUL, B_VAR, B_SQRT, B_EMIT
   } back_state_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic keep;
      logic last;
      logic bad;
   } point_type;

   typedef struct packed {
      logic [3:0] code;
      logic signed [47:0] value;
      logic undefined;
      logic last;
   } result_type;
endpackage

/* src/tws_div.sv */
// Bit-serial unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tws_div #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0] denominator,
   output logic             done,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff, den_ff, rem_in;
   logic [CNT_W-1:0] count_ff;
   logic             busy_ff, done_ff, fits;
   logic [DEN_W:0]   trial, diff;

   always_comb begin
      trial = {rem_ff, quo_ff[NUM_W-1]};
      diff = trial - {1'b0, den_ff};
      fits = trial >= {1'b0, den_ff};
      rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            count_ff <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numerator;
         rem_ff <= '0;
         den_ff <= denominator;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quotient = quo_ff;
   assign remainder = rem_ff;
endmodule

/* src/tws_isqrt.sv */
// Iterative 64-bit integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
module tws_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] x_ff, r_ff, bit_ff, trial;
   logic [5:0]  count_ff;
   logic        busy_ff, done_ff, fits;

   always_comb begin
      trial = r_ff + bit_ff;
      fits = x_ff >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            count_ff <= 6'd32;
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= radicand;
         r_ff <= '0;
         bit_ff <= 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (fits) begin
            x_ff <= x_ff - trial;
            r_ff <= (r_ff >> 1) + bit_ff;
         end else begin
            r_ff <= r_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = r_ff[31:0];
endmodule

/* src/tws_fifo.sv */
// Short point queue between the sample front end and the accumulator.
`timescale 1ns / 1ps
module tws_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tws_pkg::point_type  push_entry,
   output logic                full,
   input  logic                pop,
   output tws_pkg::point_type  pop_entry,
   output logic                empty
);
   localparam int PTR_W = $clog2(tws_pkg::QUEUE_DEPTH);

   tws_pkg::point_type entry_ff [tws_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   assign full = count_ff == (PTR_W + 1)'(tws_pkg::QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign pop_entry = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_entry;
   end
endmodule

/* src/tws_front.sv */
// Sample front end: takes samples, interpolates points and applies the window.
`timescale 1ns / 1ps
module tws_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [127:0]       req_tdata,
   input  logic [1:0]         req_tuser,
   input  logic               req_tlast,
   input  logic [4:0]         division_count,
   input  logic [30:0]        thickness_limit,
   output logic               push,
   output tws_pkg::point_type push_entry,
   input  logic               full
);
   tws_pkg::front_state_type state_ff, state_in;

   logic signed [31:0] cur_value_ff, cur_depth_ff, top_ff, base_ff;
   logic signed [31:0] prev_value_ff, prev_depth_ff;
   logic               cur_missing_ff, dead_ff, last_ff;
   logic               prev_valid_ff, prev_missing_ff;
   logic [4:0]         nd_ff, step_ff, rv_ff, rd_ff, rv_step_ff, rd_step_ff;
   logic [32:0]        qv_ff, qd_ff, qv_step_ff, qd_step_ff;
   logic               v_neg_ff, d_neg_ff;

   logic signed [31:0] in_value, in_depth;
   logic [32:0]        diff_v, diff_d, mag_v, mag_d;
   logic [4:0]         nd_clamp;
   logic               accept, interp_go, div_start, div_done, div_done_d;
   logic [32:0]        quo_v, quo_d;
   logic [4:0]         rem_v, rem_d;
   logic signed [33:0] iv_wide, id_wide;
   logic signed [31:0] iv, id;
   logic               keep_i, keep_s, bad, advance;
   logic [5:0]         rv_sum, rd_sum;
   logic               wrap_v, wrap_d;
   logic signed [32:0] thickness;

   assign in_value = req_tdata[31:0];
   assign in_depth = req_tdata[63:32];
   assign accept = req_tvalid && req_tready;

   always_comb begin
      diff_v = {in_value[31], in_value} - {prev_value_ff[31], prev_value_ff};
      diff_d = {in_depth[31], in_depth} - {prev_depth_ff[31], prev_depth_ff};
      mag_v = diff_v[32] ? (~diff_v + 33'd1) : diff_v;
      mag_d = diff_d[32] ? (~diff_d + 33'd1) : diff_d;
      if (division_count == 5'd0) nd_clamp = 5'd1;
      else if (division_count > tws_pkg::MAX_DIVISIONS) nd_clamp = tws_pkg::MAX_DIVISIONS;
      else nd_clamp = division_count;
      interp_go = prev_valid_ff && !prev_missing_ff && !req_tuser[0] && (nd_clamp > 5'd1);
   end

   tws_div #(.NUM_W(33), .DEN_W(5)) u_div_value (
      .clock(clock), .reset(reset), .start(div_start), .numerator(mag_v),
      .denominator(nd_clamp), .done(div_done), .quotient(quo_v), .remainder(rem_v)
   );

   tws_div #(.NUM_W(33), .DEN_W(5)) u_div_depth (
      .clock(clock), .reset(reset), .start(div_start), .numerator(mag_d),
      .denominator(nd_clamp), .done(div_done_d), .quotient(quo_d), .remainder(rem_d)
   );

   always_comb begin
      iv_wide = {{2{prev_value_ff[31]}}, prev_value_ff}
              + (v_neg_ff ? -$signed({1'b0, qv_ff}) : $signed({1'b0, qv_ff}));
      id_wide = {{2{prev_depth_ff[31]}}, prev_depth_ff}
              + (d_neg_ff ? -$signed({1'b0, qd_ff}) : $signed({1'b0, qd_ff}));
      iv = iv_wide[31:0];
      id = id_wide[31:0];
      keep_i = !(id < top_ff || id > base_ff);
      keep_s = !cur_missing_ff && !(cur_depth_ff < top_ff || cur_depth_ff > base_ff);
      thickness = {base_ff[31], base_ff} - {top_ff[31], top_ff};
      bad = dead_ff || (thickness <= $signed({2'b00, thickness_limit}));
      rv_sum = {1'b0, rv_ff} + {1'b0, rv_step_ff};
      rd_sum = {1'b0, rd_ff} + {1'b0, rd_step_ff};
      wrap_v = rv_sum >= {1'b0, nd_ff};
      wrap_d = rd_sum >= {1'b0, nd_ff};
   end

   always_comb begin
      state_in = state_ff;
      req_tready = 1'b0;
      div_start = 1'b0;
      push = 1'b0;
      advance = 1'b0;
      push_entry = '0;
      case (state_ff)
         tws_pkg::F_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               div_start = interp_go;
               state_in = interp_go ? tws_pkg::F_DIV : tws_pkg::F_SAMPLE;
            end
         end
         tws_pkg::F_DIV: begin
            if (div_done && div_done_d) state_in = tws_pkg::F_INTERP;
         end
         tws_pkg::F_INTERP: begin
            push_entry.value = iv;
            push_entry.keep = 1'b1;
            push = keep_i && !full;
            advance = !keep_i || !full;
            if (advance && step_ff == nd_ff - 5'd1) state_in = tws_pkg::F_SAMPLE;
         end
         tws_pkg::F_SAMPLE: begin
            push_entry.value = cur_value_ff;
            push_entry.keep = keep_s;
            push_entry.last = last_ff;
            push_entry.bad = bad;
            push = (keep_s || last_ff) && !full;
            advance = !(keep_s || last_ff) || !full;
            if (advance) state_in = tws_pkg::F_IDLE;
         end
         default: state_in = tws_pkg::F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tws_pkg::F_IDLE;
         prev_valid_ff <= 1'b0;
         prev_missing_ff <= 1'b0;
         prev_value_ff <= '0;
         prev_depth_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == tws_pkg::F_SAMPLE && advance) begin
            prev_value_ff <= cur_value_ff;
            prev_depth_ff <= cur_depth_ff;
            prev_valid_ff <= !last_ff;
            prev_missing_ff <= cur_missing_ff && !last_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_value_ff <= in_value;
         cur_depth_ff <= in_depth;
         top_ff <= req_tdata[95:64];
         base_ff <= req_tdata[127:96];
         cur_missing_ff <= req_tuser[0];
         dead_ff <= req_tuser[1];
         last_ff <= req_tlast;
         nd_ff <= nd_clamp;
         v_neg_ff <= diff_v[32];
         d_neg_ff <= diff_d[32];
      end
      if (state_ff == tws_pkg::F_DIV && div_done) begin
         qv_step_ff <= quo_v;
         qd_step_ff <= quo_d;
         rv_step_ff <= rem_v;
         rd_step_ff <= rem_d;
         qv_ff <= quo_v;
         qd_ff <= quo_d;
         rv_ff <= rem_v;
         rd_ff <= rem_d;
         step_ff <= 5'd1;
      end else if (state_ff == tws_pkg::F_INTERP && advance) begin
         step_ff <= step_ff + 5'd1;
         qv_ff <= qv_ff + qv_step_ff + {32'd0, wrap_v};
         qd_ff <= qd_ff + qd_step_ff + {32'd0, wrap_d};
         rv_ff <= wrap_v ? 5'(rv_sum - {1'b0, nd_ff}) : rv_sum[4:0];
         rd_ff <= wrap_d ? 5'(rd_sum - {1'b0, nd_ff}) : rd_sum[4:0];
      end
   end
endmodule

/* src/tws_back.sv */
// Accumulator and end-of-trace statistics sequencer.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tws_back (
   input  logic                clock,
   input  logic                reset,
   input  tws_pkg::point_type  pop_entry,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tws_pkg::result_type rsp_result
);
   tws_pkg::back_state_type state_ff, state_in;

   logic signed [31:0] v_ff;
   logic               keep_ff, last_ff, bad_ff, pop_entry_bad_ff;
   logic [63:0]        sq_ff;
   logic [31:0]        mag;

   logic [14:0]        point_count_ff, positive_count_ff, negative_count_ff;
   logic signed [46:0] running_sum_ff, positive_sum_ff, negative_sum_ff;
   logic [63:0]        square_sum_ff;
   logic signed [31:0] running_min_ff, running_max_ff, largest_positive_ff, most_negative_ff;
   logic [31:0]        largest_magnitude_ff, v_mag_ff;

   logic signed [47:0] mean_ff, meanabs_ff, meanpos_ff, meanneg_ff, var_ff;
   logic [63:0]        meansq_ff, m2_ff;
   logic [31:0]        rms_ff;
   logic [2:0]         div_sel_ff;
   logic [3:0]         code_ff;

   tws_pkg::result_type out_ff, out_in;
   logic               rsp_valid_ff;

   logic               take, acc_en, clear_acc, div_start, div_done, sqrt_start, sqrt_done;
   logic               load_out;
   logic [63:0]        div_num, div_quo;
   logic [14:0]        div_den, div_rem, n_div, np_div, nn_div;
   logic [47:0]        sum_mag, sumabs, nsum_mag, mean_mag48;
   logic [31:0]        root;
   logic               un, up, ung;

   assign mag = pop_entry.value[31] ? (~pop_entry.value + 32'd1) : pop_entry.value;
   assign take = keep_ff && (point_count_ff < tws_pkg::POINT_CAP);

   always_comb begin
      sum_mag = running_sum_ff[46] ? 48'(-{running_sum_ff[46], running_sum_ff})
                                   : {1'b0, running_sum_ff};
      sumabs = {1'b0, positive_sum_ff} - {negative_sum_ff[46], negative_sum_ff};
      nsum_mag = 48'(-{negative_sum_ff[46], negative_sum_ff});
      n_div = (point_count_ff == '0) ? 15'd1 : point_count_ff;
      np_div = (positive_count_ff == '0) ? 15'd1 : positive_count_ff;
      nn_div = (negative_count_ff == '0) ? 15'd1 : negative_count_ff;
      mean_mag48 = mean_ff[47] ? 48'(-mean_ff) : 48'(mean_ff);
      case (div_sel_ff)
         tws_pkg::DIV_SEL_MEAN: begin
            div_num = {16'd0, sum_mag};
            div_den = n_div;
         end
         tws_pkg::DIV_SEL_MEANSQ: begin
            div_num = square_sum_ff;
            div_den = n_div;
         end
         tws_pkg::DIV_SEL_MEANABS: begin
            div_num = {16'd0, sumabs};
            div_den = n_div;
         end
         tws_pkg::DIV_SEL_MEANPOS: begin
            div_num = {17'd0, positive_sum_ff};
            div_den = np_div;
         end
         default: begin
            div_num = {16'd0, nsum_mag};
            div_den = nn_div;
         end
      endcase
   end

   tws_div #(.NUM_W(64), .DEN_W(15)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numerator(div_num),
      .denominator(div_den), .done(div_done), .quotient(div_quo), .remainder(div_rem)
   );

   tws_isqrt u_isqrt (
      .clock(clock), .reset(reset), .start(sqrt_start),
      .radicand({meansq_ff[47:0], 16'd0}), .done(sqrt_done), .root(root)
   );

   always_comb begin
      un = bad_ff || (point_count_ff == '0);
      up = bad_ff || (positive_count_ff == '0);
      ung = bad_ff || (negative_count_ff == '0);
      out_in.code = code_ff;
      out_in.last = code_ff == tws_pkg::STAT_SUMNEG;
      case (code_ff)
         tws_pkg::STAT_MIN: begin
            out_in.value = 48'(running_min_ff);
            out_in.undefined = un;
         end
         tws_pkg::STAT_MAX: begin
            out_in.value = 48'(running_max_ff);
            out_in.undefined = un;
         end
         tws_pkg::STAT_MEAN: begin
            out_in.value = mean_ff;
            out_in.undefined = un;
         end
         tws_pkg::STAT_VAR: begin
            out_in.value = var_ff;
            out_in.undefined = un;
         end
         tws_pkg::STAT_RMS: begin
            out_in.value = {16'd0, rms_ff};
            out_in.undefined = un;
         end
         tws_pkg::STAT_MAXABS: begin
            out_in.value = {16'd0, largest_magnitude_ff};
            out_in.undefined = un;
         end
         tws_pkg::STAT_MEANABS: begin
            out_in.value = meanabs_ff;
            out_in.undefined = un;
         end
         tws_pkg::STAT_SUMABS: begin
            out_in.value = sumabs;
            out_in.undefined = un;
         end
         tws_pkg::STAT_MAXPOS: begin
            out_in.value = 48'(largest_positive_ff);
            out_in.undefined = up;
         end
         tws_pkg::STAT_MEANPOS: begin
            out_in.value = meanpos_ff;
            out_in.undefined = up;
         end
         tws_pkg::STAT_SUMPOS: begin
            out_in.value = 48'(positive_sum_ff);
            out_in.undefined = up;
         end
         tws_pkg::STAT_MAXNEG: begin
            out_in.value = 48'(most_negative_ff);
            out_in.undefined = ung;
         end
         tws_pkg::STAT_MEANNEG: begin
            out_in.value = meanneg_ff;
            out_in.undefined = ung;
         end
         default: begin
            out_in.value = 48'(negative_sum_ff);
            out_in.undefined = ung;
         end
      endcase
      if (out_in.undefined) out_in.value = '0;
   end

   always_comb begin
      state_in = state_ff;
      pop = 1'b0;
      acc_en = 1'b0;
      clear_acc = 1'b0;
      div_start = 1'b0;
      sqrt_start = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         tws_pkg::B_POP: begin
            if (!empty) begin
               pop = 1'b1;
               state_in = tws_pkg::B_ADD;
            end
         end
         tws_pkg::B_ADD: begin
            acc_en = take;
            state_in = last_ff ? tws_pkg::B_DSTART : tws_pkg::B_POP;
         end
         tws_pkg::B_DSTART: begin
            div_start = 1'b1;
            state_in = tws_pkg::B_DWAIT;
         end
         tws_pkg::B_DWAIT: begin
            if (div_done) begin
               state_in = (div_sel_ff == tws_pkg::DIV_SEL_MEANNEG) ? tws_pkg::B_MUL
                                                                  : tws_pkg::B_DSTART;
            end
         end
         tws_pkg::B_MUL: state_in = tws_pkg::B_VAR;
         tws_pkg::B_VAR: begin
            sqrt_start = 1'b1;
            state_in = tws_pkg::B_SQRT;
         end
         tws_pkg::B_SQRT: begin
            if (sqrt_done) state_in = tws_pkg::B_EMIT;
         end
         tws_pkg::B_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               if (code_ff == tws_pkg::STAT_SUMNEG) begin
                  clear_acc = 1'b1;
                  state_in = tws_pkg::B_POP;
               end
            end
         end
         default: state_in = tws_pkg::B_POP;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tws_pkg::B_POP;
         rsp_valid_ff <= 1'b0;
         div_sel_ff <= tws_pkg::DIV_SEL_MEAN;
         code_ff <= tws_pkg::STAT_MIN;
      end else begin
         state_ff <= state_in;
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == tws_pkg::B_DWAIT && div_done) begin
            div_sel_ff <= (div_sel_ff == tws_pkg::DIV_SEL_MEANNEG) ? tws_pkg::DIV_SEL_MEAN
                                                                   : div_sel_ff + 3'd1;
         end
         if (load_out) begin
            code_ff <= (code_ff == tws_pkg::STAT_SUMNEG) ? tws_pkg::STAT_MIN
                                                         : code_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_acc) begin
         point_count_ff <= '0;
         positive_count_ff <= '0;
         negative_count_ff <= '0;
         running_sum_ff <= '0;
         positive_sum_ff <= '0;
         negative_sum_ff <= '0;
         square_sum_ff <= '0;
         running_min_ff <= 32'sh7FFF_FFFF;
         running_max_ff <= 32'sh8000_0000;
         largest_magnitude_ff <= '0;
         largest_positive_ff <= '0;
         most_negative_ff <= '0;
      end else if (acc_en) begin
         point_count_ff <= point_count_ff + 15'd1;
         if (v_ff < running_min_ff) running_min_ff <= v_ff;
         if (v_ff > running_max_ff) running_max_ff <= v_ff;
         running_sum_ff <= running_sum_ff + 47'(v_ff);
         square_sum_ff <= square_sum_ff + {16'd0, sq_ff[63:16]};
         if (!v_ff[31]) begin
            positive_count_ff <= positive_count_ff + 15'd1;
            positive_sum_ff <= positive_sum_ff + 47'(v_ff);
            if (v_ff > largest_positive_ff) largest_positive_ff <= v_ff;
         end else begin
            negative_count_ff <= negative_count_ff + 15'd1;
            negative_sum_ff <= negative_sum_ff + 47'(v_ff);
            if (v_ff < most_negative_ff) most_negative_ff <= v_ff;
         end
         if (v_mag_ff > largest_magnitude_ff) largest_magnitude_ff <= v_mag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         v_ff <= pop_entry.value;
         v_mag_ff <= mag;
         sq_ff <= mag * mag;
         keep_ff <= pop_entry.keep;
         last_ff <= pop_entry.last;
      end
      if (state_ff == tws_pkg::B_ADD && last_ff) bad_ff <= pop_entry_bad_ff;
      if (state_ff == tws_pkg::B_DWAIT && div_done) begin
         case (div_sel_ff)
            tws_pkg::DIV_SEL_MEAN:
               mean_ff <= running_sum_ff[46] ? -$signed(div_quo[47:0]) : $signed(div_quo[47:0]);
            tws_pkg::DIV_SEL_MEANSQ: meansq_ff <= div_quo;
            tws_pkg::DIV_SEL_MEANABS: meanabs_ff <= div_quo[47:0];
            tws_pkg::DIV_SEL_MEANPOS: meanpos_ff <= div_quo[47:0];
            default: meanneg_ff <= -$signed(div_quo[47:0]);
         endcase
      end
      if (state_ff == tws_pkg::B_MUL) m2_ff <= (mean_mag48[31:0] * mean_mag48[31:0]) >> 16;
      if (state_ff == tws_pkg::B_VAR) begin
         var_ff <= (meansq_ff > m2_ff) ? 48'(meansq_ff - m2_ff) : 48'd0;
      end
      if (sqrt_done) rms_ff <= root;
      if (load_out) out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (pop) pop_entry_bad_ff <= pop_entry.bad;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_result = out_ff;

   `ASSERT_ALWAYS(a_point_cap, clock, reset, point_count_ff <= tws_pkg::POINT_CAP)
   `ASSERT_ALWAYS(a_count_split, clock, reset, 16'(positive_count_ff) + 16'(negative_count_ff) == 16'(point_count_ff))
   `ASSERT_IMPLIES(a_undef_zero, clock, reset, rsp_valid_ff && out_ff.undefined, out_ff.value == '0)
   `ASSERT_IMPLIES(a_div_in_wait, clock, reset, div_done, state_ff == tws_pkg::B_DWAIT)
   `ASSERT_IMPLIES(a_last_code, clock, reset, rsp_valid_ff && out_ff.last, out_ff.code == tws_pkg::STAT_SUMNEG)
endmodule

/* src/trace_window_statistics.sv */
// Top level of the trace window statistics block.
//
// Samples of one trace arrive on the req_ stream in depth order, one
// transaction per layer; req_tlast marks the last sample of the trace.
// The front end interpolates division_count-1 points, with division_count
// clamped to 1..16, before each sample that follows another one of its
// trace, unless either is missing: a divider run, then one point per cycle
// while the point queue is not full. It queues the points in the window
// and the last sample. The accumulator pops a point and adds it before it
// takes the next one. After the last sample the back end runs five serial
// divisions, a multiply and a square root, then sends the fourteen
// statistics on the rsp_ stream; rsp_tlast closes the trace. A stalled
// receiver holds the current result; new samples are taken until the point
// queue fills. Configuration is written through the csr_ port. Reset
// clears all accumulators and sets division_count to 1 and the thickness
// limit to 0.
`timescale 1ns / 1ps
module trace_window_statistics (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,  // sample_value, sample_depth, window_top, window_base
   input  logic [1:0]   req_tuser,  // sample_missing, trace_dead
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata,  // stat_code, stat_value, zero fill
   output logic         rsp_tuser,  // stat_undefined
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [30:0]  csr_wdata
);
   logic [4:0]  division_count_ff;
   logic [30:0] thickness_limit_ff;

   tws_pkg::point_type  push_entry, pop_entry;
   tws_pkg::result_type result;
   logic                push, full, pop, empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         division_count_ff <= 5'd1;
         thickness_limit_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            tws_pkg::REG_DIVISION_COUNT: division_count_ff <= csr_wdata[4:0];
            tws_pkg::REG_THICKNESS_LIMIT: thickness_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   tws_front u_front (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser), .req_tlast(req_tlast),
      .division_count(division_count_ff), .thickness_limit(thickness_limit_ff),
      .push(push), .push_entry(push_entry), .full(full)
   );

   tws_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .push_entry(push_entry), .full(full),
      .pop(pop), .pop_entry(pop_entry), .empty(empty)
   );

   tws_back u_back (
      .clock(clock), .reset(reset), .pop_entry(pop_entry), .empty(empty), .pop(pop),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready), .rsp_result(result)
   );

   assign rsp_tdata = {4'd0, result.value, result.code};
   assign rsp_tuser = result.undefined;
   assign rsp_tlast = result.last;
endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the trace window statistics block.
`timescale 1ns / 1ps
module tb_top;
   typedef struct {
      logic [31:0] value;
      logic [31:0] depth;
      logic [31:0] top;
      logic [31:0] base;
      logic missing;
      logic dead;
      logic last;
   } sample_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [127:0] req_tdata;
   logic [1:0] req_tuser;
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [55:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_we;
   logic csr_index;
   logic [30:0] csr_wdata;

   sample_type pending_samples[$];
   tws_pkg::result_type expected_stats[$];
   int error_count = 0;
   bit steady = 0;
   bit hold_request = 0;
   int hold_cycles = 0;

   logic [4:0] cfg_divisions;
   longint cfg_thickness;
   longint n_points, n_pos, n_neg, sum_all, sum_pos, sum_neg;
   longint lo_val, hi_val, big_mag, big_pos, big_neg, last_val, last_depth;
   longint unsigned sum_sq;
   bit has_prev, prev_missing;

   trace_window_statistics u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= x) root = trial;
      end
      return root;
   endfunction

   task automatic clear_trace_state();
      n_points = 0; n_pos = 0; n_neg = 0;
      sum_all = 0; sum_pos = 0; sum_neg = 0; sum_sq = 0;
      lo_val = 64'sh7FFFFFFF; hi_val = -64'sh80000000;
      big_mag = 0; big_pos = 0; big_neg = 0;
      last_val = 0; last_depth = 0;
      has_prev = 0; prev_missing = 0;
   endtask

   task automatic accumulate_point(longint v, longint d, bit skip, longint top, longint base);
      longint mag;
      if (skip || d < top || d > base || n_points >= tws_pkg::POINT_CAP) return;
      n_points++;
      if (v < lo_val) lo_val = v;
      if (v > hi_val) hi_val = v;
      sum_all += v;
      mag = v < 0 ? -v : v;
      sum_sq += (longint'(mag) * longint'(mag)) >>> 16;
      if (v >= 0) begin
         n_pos++; sum_pos += v;
         if (v > big_pos) big_pos = v;
      end else begin
         n_neg++; sum_neg += v;
         if (v < big_neg) big_neg = v;
      end
      if (mag > big_mag) big_mag = mag;
   endtask

   task automatic push_stat(logic [3:0] code, longint val, bit undef);
      tws_pkg::result_type r;
      if (undef) val = 0;
      if (val > 64'sh7FFFFFFFFFFF) val = 64'sh7FFFFFFFFFFF;
      if (val < -64'sh800000000000) val = -64'sh800000000000;
      r.code = code;
      r.value = val[47:0];
      r.undefined = undef;
      r.last = (code == tws_pkg::STAT_SUMNEG);
      expected_stats.push_back(r);
   endtask

   task automatic predict_sample(sample_type s);
      longint v, d, top, base, nd, n, np, nn, mean, sum_abs;
      longint unsigned mean_sq, mag, mean_mag_sq, variance;
      bit bad, no_pts, no_pos, no_neg;
      v = longint'($signed(s.value));
      d = longint'($signed(s.depth));
      top = longint'($signed(s.top));
      base = longint'($signed(s.base));
      nd = cfg_divisions;
      if (nd < 1) nd = 1;
      if (nd > tws_pkg::MAX_DIVISIONS) nd = tws_pkg::MAX_DIVISIONS;
      if (has_prev && nd > 1)
         for (longint t = 1; t < nd; t++)
            accumulate_point(last_val + ((v - last_val) * t) / nd,
                             last_depth + ((d - last_depth) * t) / nd,
                             s.missing || prev_missing, top, base);
      accumulate_point(v, d, s.missing, top, base);
      last_val = v; last_depth = d; has_prev = 1; prev_missing = s.missing;
      if (!s.last) return;
      bad = s.dead || (base - top <= cfg_thickness);
      no_pts = bad || n_points == 0;
      no_pos = bad || n_pos == 0;
      no_neg = bad || n_neg == 0;
      n = n_points ? n_points : 1;
      np = n_pos ? n_pos : 1;
      nn = n_neg ? n_neg : 1;
      mean = sum_all / n;
      mean_sq = sum_sq / longint'(n);
      mag = mean < 0 ? -mean : mean;
      mean_mag_sq = (mag * mag) >> 16;
      variance = mean_sq > mean_mag_sq ? mean_sq - mean_mag_sq : 0;
      sum_abs = sum_pos - sum_neg;
      push_stat(tws_pkg::STAT_MIN, lo_val, no_pts);
      push_stat(tws_pkg::STAT_MAX, hi_val, no_pts);
      push_stat(tws_pkg::STAT_MEAN, mean, no_pts);
      push_stat(tws_pkg::STAT_VAR, longint'(variance), no_pts);
      push_stat(tws_pkg::STAT_RMS, longint'(int_sqrt(mean_sq << 16)), no_pts);
      push_stat(tws_pkg::STAT_MAXABS, big_mag, no_pts);
      push_stat(tws_pkg::STAT_MEANABS, sum_abs / n, no_pts);
      push_stat(tws_pkg::STAT_SUMABS, sum_abs, no_pts);
      push_stat(tws_pkg::STAT_MAXPOS, big_pos, no_pos);
      push_stat(tws_pkg::STAT_MEANPOS, sum_pos / np, no_pos);
      push_stat(tws_pkg::STAT_SUMPOS, sum_pos, no_pos);
      push_stat(tws_pkg::STAT_MAXNEG, big_neg, no_neg);
      push_stat(tws_pkg::STAT_MEANNEG, sum_neg / nn, no_neg);
      push_stat(tws_pkg::STAT_SUMNEG, sum_neg, no_neg);
      clear_trace_state();
   endtask

   always @(posedge clock) begin
      sample_type s;
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= '0;
         req_tuser <= '0;
         req_tlast <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            predict_sample('{req_tdata[31:0], req_tdata[63:32], req_tdata[95:64],
                             req_tdata[127:96], req_tuser[0], req_tuser[1], req_tlast});
         if (pending_samples.size() > 0 && (steady || $urandom_range(99) >= 24)) begin
            s = pending_samples.pop_front();
            req_tvalid <= 1;
            req_tdata <= {s.base, s.top, s.depth, s.value};
            req_tuser <= {s.dead, s.missing};
            req_tlast <= s.last;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   always @(posedge clock) begin
      tws_pkg::result_type r;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_stats.size() == 0) begin
               $error("unexpected result code %0d", rsp_tdata[3:0]);
               error_count++;
            end else begin
               r = expected_stats.pop_front();
               if (rsp_tdata[3:0] !== r.code) begin
                  $error("stat_code expected %0d actual %0d", r.code, rsp_tdata[3:0]);
                  error_count++;
               end
               if (rsp_tdata[51:4] !== r.value) begin
                  $error("stat_value expected %h actual %h", r.value, rsp_tdata[51:4]);
                  error_count++;
               end
               if (rsp_tuser !== r.undefined) begin
                  $error("stat_undefined expected %0d actual %0d", r.undefined, rsp_tuser);
                  error_count++;
               end
               if (rsp_tlast !== r.last) begin
                  $error("last_of_run expected %0d actual %0d", r.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (hold_request && hold_cycles == 0) hold_cycles = 900;
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= steady || $urandom_range(99) >= 24;
         end
      end
   end

   task automatic add_sample(longint v, longint d, longint top, longint base,
                             bit missing, bit dead, bit last);
      sample_type s;
      s.value = v[31:0]; s.depth = d[31:0]; s.top = top[31:0]; s.base = base[31:0];
      s.missing = missing; s.dead = dead; s.last = last;
      pending_samples.push_back(s);
   endtask

   function automatic longint pick_value();
      case ($urandom_range(7))
         0: return -64'sh80000000;
         1: return 64'sh7FFFFFFF;
         2: return 0;
         3: return longint'($signed(16'($urandom))) <<< 4;
         default: return longint'($signed($urandom));
      endcase
   endfunction

   task automatic add_random_trace(int len);
      longint top, base, d, step;
      int style;
      style = $urandom_range(19);
      top = longint'($signed($urandom)) >>> 1;
      step = $urandom_range(1 << 20, 1);
      base = top + step * len - $urandom_range(32'(step * 2));
      if (style == 0) base = top + cfg_thickness - $urandom_range(1);
      d = top - $urandom_range(32'(step * 2));
      for (int i = 0; i < len; i++) begin
         if (style < 3)
            add_sample(longint'($signed($urandom)), longint'($signed($urandom)),
                       longint'($signed($urandom)), longint'($signed($urandom)),
                       $urandom_range(1), $urandom_range(1), i == len - 1);
         else
            add_sample(pick_value(), d, top, base, $urandom_range(9) == 0,
                       $urandom_range(11) == 0, i == len - 1);
         d += step;
      end
   endtask

   task automatic write_register(logic index, logic [30:0] data);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= index;
      csr_wdata <= data;
      if (index == tws_pkg::REG_DIVISION_COUNT) cfg_divisions = data[4:0];
      else cfg_thickness = data;
      @(posedge clock);
      csr_we <= 0;
   endtask

   task automatic drain_all();
      while (pending_samples.size() > 0 || req_tvalid || expected_stats.size() > 0)
         @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   initial begin
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 0;
      rsp_tready = 0;
      csr_we = 0;
      csr_index = tws_pkg::REG_DIVISION_COUNT;
      csr_wdata = '0;
      cfg_divisions = 1;
      cfg_thickness = 0;
      clear_trace_state();
      reset = 1;
      repeat (7) @(posedge clock);
      reset <= 0;

      // Extremes, a single-sample trace, missing data, dead and thin windows.
      add_sample(-64'sh80000000, 0, -64'sh80000000, 64'sh7FFFFFFF, 0, 0, 0);
      add_sample(64'sh7FFFFFFF, 1, -64'sh80000000, 64'sh7FFFFFFF, 0, 0, 0);
      add_sample(0, 2, -64'sh80000000, 64'sh7FFFFFFF, 0, 0, 0);
      add_sample(-1, 64'sh7FFFFFFF, -64'sh80000000, 64'sh7FFFFFFF, 0, 0, 1);
      add_sample(64'sh12345, 5, 0, 10, 0, 0, 1);
      add_sample(5, 5, 0, 10, 1, 0, 0);
      add_sample(7, 6, 0, 10, 1, 0, 1);
      add_sample(-300, 1, 0, 10, 0, 1, 0);
      add_sample(400, 2, 0, 10, 0, 1, 1);
      add_sample(100, 3, 3, 3, 0, 0, 1);
      add_sample(100, -5, 0, 10, 0, 0, 0);
      add_sample(-200, 20, 0, 10, 0, 0, 1);
      add_sample(-64'sh10000, 0, -64'sh80000000, 64'sh7FFFFFFF, 0, 0, 0);
      add_sample(-64'sh20000, 4, -64'sh80000000, 64'sh7FFFFFFF, 0, 0, 1);
      drain_all();

      write_register(tws_pkg::REG_DIVISION_COUNT, 31'd4);
      add_sample(64'sh40000, 0, 0, 64'sh100, 0, 0, 0);
      add_sample(-64'sh40000, 64'sh80, 0, 64'sh100, 1, 0, 0);
      add_sample(64'sh7FFFFFFF, 64'sh100, 0, 64'sh100, 0, 0, 0);
      add_sample(-64'sh80000000, 64'sh200, 0, 64'sh100, 0, 0, 1);
      drain_all();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_register(tws_pkg::REG_DIVISION_COUNT, 31'd0);
                  write_register(tws_pkg::REG_THICKNESS_LIMIT, 31'h7FFFFFFF); end
            1: begin write_register(tws_pkg::REG_DIVISION_COUNT, 31'd16);
                  write_register(tws_pkg::REG_THICKNESS_LIMIT, 31'd0); end
            2: write_register(tws_pkg::REG_DIVISION_COUNT, 31'd31);
            3: begin write_register(tws_pkg::REG_DIVISION_COUNT, 31'd1);
                  write_register(tws_pkg::REG_THICKNESS_LIMIT,
                                 31'($urandom_range(1 << 22))); end
            4: write_register(tws_pkg::REG_DIVISION_COUNT, 31'($urandom_range(15, 2)));
            default: begin
                  write_register(tws_pkg::REG_DIVISION_COUNT,
                                 31'(1 << $urandom_range(4)));
                  write_register(tws_pkg::REG_THICKNESS_LIMIT, 31'($urandom)); end
         endcase
         steady = (phase == 3);
         for (int k = 0; k < 12; k++) add_random_trace($urandom_range(10, 1));
         if (phase == 4) begin
            while (expected_stats.size() == 0) @(posedge clock);
            hold_request = 1;
            wait (hold_cycles > 0);
            hold_request = 0;
         end
         drain_all();
      end

      // One long trace at the largest division count.
      steady = 0;
      write_register(tws_pkg::REG_DIVISION_COUNT, 31'd16);
      write_register(tws_pkg::REG_THICKNESS_LIMIT, 31'd0);
      for (int i = 0; i < 60; i++)
         add_sample(pick_value(), longint'(i) <<< 8, 0, 64'sh7FFFFFFF, 0, 0, i == 59);
      drain_all();

      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("tb_top: done, errors");
      $finish;
   end
endmodule

/* trace_window_statistics.f */
+incdir+src
src/tws_pkg.sv
src/tws_div.sv
src/tws_isqrt.sv
src/tws_fifo.sv
src/tws_front.sv
src/tws_back.sv
src/trace_window_statistics.sv
sim/tb_top.sv
